[sv/lsg_pkg.sv]
// Shared types, constants and the saturation helper function of the 1-D Laplacian stencil block.
`default_nettype none
package lsg_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SPACING_W  = 31;
  localparam int unsigned MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PERIODIC  = 2'd0,
    MODE_DIRICHLET = 2'd1,
    MODE_NEUMANN   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_MODE   = 3'd0,
    CFG_RIGHT_MODE  = 3'd1,
    CFG_LEFT_VALUE  = 3'd2,
    CFG_RIGHT_VALUE = 3'd3,
    CFG_SPACING     = 3'd4,
    CFG_SCALE       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_GH_MUL,
    S_GH_SUM,
    S_L_DIFF,
    S_L_MUL,
    S_L_OUT
  } state_e;

  // Which point of the line the result being computed belongs to.
  typedef enum logic [1:0] {
    KIND_INT,
    KIND_FIRST,
    KIND_LAST
  } kind_e;

  typedef struct packed {
    logic  accept;
    logic  gh_mul;
    logic  gh_sum;
    logic  l_diff;
    logic  l_mul;
    logic  l_out;
    kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic has_int;
    logic fin;
    logic single;
    logic out_free;
  } status_t;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/laplacian_stencil_1d_ghost_bc.sv]
// Top level of the streaming 1-D second-difference Laplacian with ghost boundaries.
// The block takes one line of signed Q16.16 samples, one per input transfer, and returns
// laplacian_scale * (left - 2*centre + right) for every point, truncated and saturated to
// signed Q16.16. Interior point i-1 is returned after sample i arrives. Point 0 and the
// last point need boundary ghosts, so both come after the last sample (final_sample set, or
// the sample at index MAX_POINTS-1): first the last interior point if any, then point 0,
// then the last point with run_end set. Each boundary picks its ghost by mode: periodic
// takes the opposite end, Dirichlet gives 2*value - edge, Neumann gives edge +
// spacing*value, and the unused mode code gives a ghost of zero. One sample is worked
// on at a time, with the input stalled until the sequencer is idle again: a sample that
// yields no result is only captured, one that yields an interior result then goes through
// difference, multiply, and sum with load of the output register, and a final sample adds
// the ghost multiply and add plus the difference, multiply, and sum with load of the output
// register for each boundary result. Each result waits in the output register while
// out_stall_i is high; the next sample may be taken meanwhile.
// Configuration writes through cfg_we_i take effect at once and belong in idle periods.
`default_nettype none
module laplacian_stencil_1d_ghost_bc (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [lsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [lsg_pkg::DATA_W-1:0]    cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [lsg_pkg::DATA_W-1:0]    sample_i,
  input  wire logic                                 final_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [lsg_pkg::DATA_W-1:0]    derivative_o,
  output logic             [lsg_pkg::IDX_W-1:0]     point_index_o,
  output logic                                      run_end_o
);

  lsg_pkg::cmd_t    cmd;
  lsg_pkg::status_t status;

  // The controller steps through capture, ghost and stencil phases.
  lsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, sample history and all arithmetic.
  lsg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (sample_i),
    .final_sample_i (final_sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .derivative_o   (derivative_o),
    .point_index_o  (point_index_o),
    .run_end_o      (run_end_o)
  );

  // Once a sample is transferred the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took no busy cycle after an input transfer");

  // A result held back by the receiver stays valid and unchanged.
  a_out_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(derivative_o) &&
    $stable(point_index_o) && $stable(run_end_o))
    else $error("waiting result changed while the output was stalled");

  // The sequencer only loads a result into a free output register.
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.l_out |-> status.out_free)
    else $error("output register loaded while still occupied");

endmodule
`default_nettype wire

[sv/lsg_ctrl.sv]
// Sequencing state machine of the 1-D Laplacian stencil block.
`default_nettype none
module lsg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lsg_pkg::status_t status_i,
  output lsg_pkg::cmd_t         cmd_o
);

  lsg_pkg::state_e state_q, state_d;
  lsg_pkg::kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsg_pkg::S_IDLE;
      kind_q  <= lsg_pkg::KIND_INT;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      lsg_pkg::S_IDLE: begin
        if (in_valid_i) state_d = lsg_pkg::S_START;
      end
      lsg_pkg::S_START: begin
        if (status_i.has_int) begin
          kind_d  = lsg_pkg::KIND_INT;
          state_d = lsg_pkg::S_L_DIFF;
        end else if (status_i.fin) begin
          state_d = lsg_pkg::S_GH_MUL;
        end else begin
          state_d = lsg_pkg::S_IDLE;
        end
      end
      lsg_pkg::S_GH_MUL: state_d = lsg_pkg::S_GH_SUM;
      lsg_pkg::S_GH_SUM: begin
        kind_d  = lsg_pkg::KIND_FIRST;
        state_d = lsg_pkg::S_L_DIFF;
      end
      lsg_pkg::S_L_DIFF: state_d = lsg_pkg::S_L_MUL;
      lsg_pkg::S_L_MUL:  state_d = lsg_pkg::S_L_OUT;
      lsg_pkg::S_L_OUT: begin
        if (status_i.out_free) begin
          case (kind_q)
            lsg_pkg::KIND_INT: begin
              state_d = status_i.fin ? lsg_pkg::S_GH_MUL : lsg_pkg::S_IDLE;
            end
            lsg_pkg::KIND_FIRST: begin
              if (status_i.single) begin
                state_d = lsg_pkg::S_IDLE;
              end else begin
                kind_d  = lsg_pkg::KIND_LAST;
                state_d = lsg_pkg::S_L_DIFF;
              end
            end
            default: state_d = lsg_pkg::S_IDLE;
          endcase
        end
      end
      default: state_d = lsg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = kind_q;
    in_stall_o   = (state_q != lsg_pkg::S_IDLE);
    unique case (state_q)
      lsg_pkg::S_IDLE:   cmd_o.accept = in_valid_i;
      lsg_pkg::S_GH_MUL: cmd_o.gh_mul = 1'b1;
      lsg_pkg::S_GH_SUM: cmd_o.gh_sum = 1'b1;
      lsg_pkg::S_L_DIFF: cmd_o.l_diff = 1'b1;
      lsg_pkg::S_L_MUL:  cmd_o.l_mul  = 1'b1;
      lsg_pkg::S_L_OUT:  cmd_o.l_out  = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/lsg_dp.sv]
// Datapath of the 1-D Laplacian stencil block: config, sample history, ghosts, stencil math.
`default_nettype none
module lsg_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lsg_pkg::cmd_t                        cmd_i,
  output lsg_pkg::status_t                          status_o,
  input  wire logic signed [lsg_pkg::DATA_W-1:0]    sample_i,
  input  wire logic                                 final_sample_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [lsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [lsg_pkg::DATA_W-1:0]    cfg_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [lsg_pkg::DATA_W-1:0]    derivative_o,
  output logic             [lsg_pkg::IDX_W-1:0]     point_index_o,
  output logic                                      run_end_o
);

  // Configuration registers.
  logic        [lsg_pkg::MODE_W-1:0]    left_mode_q, right_mode_q;
  logic signed [lsg_pkg::DATA_W-1:0]    left_value_q, right_value_q, scale_q;
  logic        [lsg_pkg::SPACING_W-1:0] spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_mode_q   <= '0;
      right_mode_q  <= '0;
      left_value_q  <= '0;
      right_value_q <= '0;
      spacing_q     <= lsg_pkg::SPACING_W'(65536);
      scale_q       <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsg_pkg::CFG_LEFT_MODE:   left_mode_q   <= cfg_data_i[lsg_pkg::MODE_W-1:0];
        lsg_pkg::CFG_RIGHT_MODE:  right_mode_q  <= cfg_data_i[lsg_pkg::MODE_W-1:0];
        lsg_pkg::CFG_LEFT_VALUE:  left_value_q  <= $signed(cfg_data_i);
        lsg_pkg::CFG_RIGHT_VALUE: right_value_q <= $signed(cfg_data_i);
        lsg_pkg::CFG_SPACING:     spacing_q     <= cfg_data_i[lsg_pkg::SPACING_W-1:0];
        lsg_pkg::CFG_SCALE:       scale_q       <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sample history and the captured view of the item in progress.
  logic        [lsg_pkg::CNT_W-1:0]  cnt_q, idx_q;
  logic                              fin_q;
  logic signed [lsg_pkg::DATA_W-1:0] first_q, second_q, older_q, newer_q;
  logic signed [lsg_pkg::DATA_W-1:0] cur_q, prev_q, pprev_q;
  logic                              fin_in;

  assign fin_in = final_sample_i || (cnt_q >= lsg_pkg::CNT_W'(lsg_pkg::MAX_POINTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      fin_q <= 1'b0;
    end else if (cmd_i.accept) begin
      cnt_q <= fin_in ? '0 : cnt_q + lsg_pkg::CNT_W'(1);
      idx_q <= cnt_q;
      fin_q <= fin_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q   <= sample_i;
      prev_q  <= newer_q;
      pprev_q <= older_q;
      older_q <= newer_q;
      newer_q <= sample_i;
      if (cnt_q == '0) first_q <= sample_i;
      if (cnt_q == lsg_pkg::CNT_W'(1)) second_q <= sample_i;
    end
  end

  // Ghost values: the Neumann product is registered before the add.
  logic signed [63:0]                prodl_q, prodr_q;
  logic signed [lsg_pkg::DATA_W-1:0] gl_q, gr_q, gl_d, gr_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.gh_mul) begin
      prodl_q <= $signed({1'b0, spacing_q}) * left_value_q;
      prodr_q <= $signed({1'b0, spacing_q}) * right_value_q;
    end
    if (cmd_i.gh_sum) begin
      gl_q <= gl_d;
      gr_q <= gr_d;
    end
  end

  always_comb begin
    case (left_mode_q)
      lsg_pkg::MODE_PERIODIC:  gl_d = cur_q;
      lsg_pkg::MODE_DIRICHLET: gl_d = lsg_pkg::sat32((64'(left_value_q) <<< 1) - 64'(first_q));
      lsg_pkg::MODE_NEUMANN:   gl_d = lsg_pkg::sat32(64'(first_q) + (prodl_q >>> 16));
      default:                 gl_d = '0;
    endcase
    case (right_mode_q)
      lsg_pkg::MODE_PERIODIC:  gr_d = first_q;
      lsg_pkg::MODE_DIRICHLET: gr_d = lsg_pkg::sat32((64'(right_value_q) <<< 1) - 64'(cur_q));
      lsg_pkg::MODE_NEUMANN:   gr_d = lsg_pkg::sat32(64'(cur_q) + (prodr_q >>> 16));
      default:                 gr_d = '0;
    endcase
  end

  // Stencil: second difference, split multiply, then sum and saturate.
  logic                              single;
  logic signed [lsg_pkg::DATA_W-1:0] op_l, op_c, op_r;
  logic signed [33:0]                diff_q;
  logic signed [49:0]                ph_q;
  logic signed [48:0]                pl_q;

  assign single = (idx_q == '0);

  always_comb begin
    case (cmd_i.kind)
      lsg_pkg::KIND_FIRST: begin
        op_l = gl_q;
        op_c = first_q;
        op_r = single ? gr_q : second_q;
      end
      lsg_pkg::KIND_LAST: begin
        op_l = prev_q;
        op_c = cur_q;
        op_r = gr_q;
      end
      default: begin
        op_l = pprev_q;
        op_c = prev_q;
        op_r = cur_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.l_diff) begin
      diff_q <= 34'(op_l) - (34'(op_c) <<< 1) + 34'(op_r);
    end
    if (cmd_i.l_mul) begin
      ph_q <= $signed(diff_q[33:16]) * scale_q;
      pl_q <= $signed({1'b0, diff_q[15:0]}) * scale_q;
    end
  end

  // Output register.
  logic                              out_valid_q;
  logic signed [lsg_pkg::DATA_W-1:0] deriv_q;
  logic        [lsg_pkg::IDX_W-1:0]  pidx_q, pidx_d;
  logic                              rend_q, rend_d;

  always_comb begin
    case (cmd_i.kind)
      lsg_pkg::KIND_FIRST: begin
        pidx_d = '0;
        rend_d = single;
      end
      lsg_pkg::KIND_LAST: begin
        pidx_d = lsg_pkg::IDX_W'(idx_q);
        rend_d = 1'b1;
      end
      default: begin
        pidx_d = lsg_pkg::IDX_W'(idx_q - lsg_pkg::CNT_W'(1));
        rend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.l_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.l_out) begin
      deriv_q <= lsg_pkg::sat32(64'(ph_q) + 64'(pl_q >>> 16));
      pidx_q  <= pidx_d;
      rend_q  <= rend_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign derivative_o  = deriv_q;
  assign point_index_o = pidx_q;
  assign run_end_o     = rend_q;

  assign status_o.has_int  = (idx_q >= lsg_pkg::CNT_W'(2));
  assign status_o.fin      = fin_q;
  assign status_o.single   = single;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

[test/laplacian_stencil_1d_ghost_bc_tb.sv]
// Self-checking testbench for the streaming 1-D Laplacian stencil with ghost boundaries.
`default_nettype none
module laplacian_stencil_1d_ghost_bc_tb;

  localparam int unsigned DATA_W    = lsg_pkg::DATA_W;
  localparam int unsigned MODE_W    = lsg_pkg::MODE_W;
  localparam int unsigned IDX_W     = lsg_pkg::IDX_W;
  localparam int unsigned SPACING_W = lsg_pkg::SPACING_W;

  // The fourth mode code is not a real boundary mode; the block gives a zero ghost for it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh00010000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ends_line;
  } sample_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] derivative;
    logic [IDX_W-1:0]         point;
    logic                     run_end;
  } point_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we   = 1'b0;
  lsg_pkg::cfg_idx_e        cfg_idx  = lsg_pkg::CFG_LEFT_MODE;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic signed [DATA_W-1:0] sample_d = '0;
  logic                     final_d  = 1'b0;
  logic                     out_stall = 1'b0;

  logic                     in_stall;
  logic                     out_valid;
  logic signed [DATA_W-1:0] derivative;
  logic [IDX_W-1:0]         point_index;
  logic                     run_end;

  laplacian_stencil_1d_ghost_bc uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample_d),
    .final_sample_i (final_d),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .derivative_o   (derivative),
    .point_index_o  (point_index),
    .run_end_o      (run_end)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers, in their reset state.
  logic [MODE_W-1:0]        left_mode_q   = lsg_pkg::MODE_PERIODIC;
  logic [MODE_W-1:0]        right_mode_q  = lsg_pkg::MODE_PERIODIC;
  logic signed [DATA_W-1:0] left_value_q  = '0;
  logic signed [DATA_W-1:0] right_value_q = '0;
  logic [SPACING_W-1:0]     spacing_q     = 31'h0001_0000;
  logic signed [DATA_W-1:0] scale_q       = Q_ONE;

  // Shadow copy of the line state held by the block.
  logic signed [DATA_W-1:0] first_pt  = '0;
  logic signed [DATA_W-1:0] second_pt = '0;
  logic signed [DATA_W-1:0] older_pt  = '0;
  logic signed [DATA_W-1:0] newer_pt  = '0;
  int unsigned              points_in_line = 0;

  sample_item_t  line_items[$];
  point_result_t pending_results[$];

  int unsigned samples_offered = 0;
  int unsigned samples_taken   = 0;
  int unsigned results_taken   = 0;
  int unsigned errors          = 0;

  function automatic logic signed [DATA_W-1:0] clamp_q(longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return x[DATA_W-1:0];
  endfunction

  // Ghost value beyond one end of the line; opposite is the sample at the other end.
  function automatic logic signed [DATA_W-1:0] boundary_ghost(logic [MODE_W-1:0] mode,
      logic signed [DATA_W-1:0] value, logic signed [DATA_W-1:0] edge_pt,
      logic signed [DATA_W-1:0] opposite);
    case (mode)
      lsg_pkg::MODE_PERIODIC:  return opposite;
      lsg_pkg::MODE_DIRICHLET: return clamp_q(2 * longint'(value) - longint'(edge_pt));
      lsg_pkg::MODE_NEUMANN:   return clamp_q(longint'(edge_pt) +
                                   ((longint'(spacing_q) * longint'(value)) >>> 16));
      default:                 return '0;
    endcase
  endfunction

  // The second difference is exact; it is split into whole and fractional parts so that
  // the scale multiply truncates exactly as a single wide product would.
  function automatic logic signed [DATA_W-1:0] scaled_second_diff(logic signed [DATA_W-1:0] l,
      logic signed [DATA_W-1:0] c, logic signed [DATA_W-1:0] r);
    longint d, dh, dl;
    d  = longint'(l) - 2 * longint'(c) + longint'(r);
    dh = d >>> 16;
    dl = d - dh * 65536;
    return clamp_q(dh * longint'(scale_q) + ((dl * longint'(scale_q)) >>> 16));
  endfunction

  function automatic void queue_result(logic signed [DATA_W-1:0] value, int unsigned idx,
      logic ends);
    point_result_t r;
    r.derivative = value;
    r.point      = idx[IDX_W-1:0];
    r.run_end    = ends;
    pending_results.push_back(r);
  endfunction

  // Advances the shadow line state by one sample and queues the results it causes.
  function automatic void absorb_sample(logic signed [DATA_W-1:0] c, logic ends);
    int unsigned i;
    logic closes;
    logic signed [DATA_W-1:0] gl, gr;
    i = points_in_line;
    // A line that reaches the point limit is closed even without the marker.
    closes = ends || (i >= lsg_pkg::MAX_POINTS - 1);
    if (i == 0) first_pt = c;
    if (i == 1) second_pt = c;
    if (i >= 2) queue_result(scaled_second_diff(older_pt, newer_pt, c), i - 1, 1'b0);
    if (closes) begin
      gl = boundary_ghost(left_mode_q, left_value_q, first_pt, c);
      gr = boundary_ghost(right_mode_q, right_value_q, c, first_pt);
      if (i == 0) begin
        queue_result(scaled_second_diff(gl, c, gr), 0, 1'b1);
      end else begin
        queue_result(scaled_second_diff(gl, first_pt, second_pt), 0, 1'b0);
        queue_result(scaled_second_diff(newer_pt, c, gr), i, 1'b1);
      end
      points_in_line = 0;
    end else begin
      points_in_line = i + 1;
    end
    older_pt = newer_pt;
    newer_pt = c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d, expected %0d", results_taken, what,
             got, want);
    errors++;
  endtask

  // Each side alternates between calm spells with no waits and busy spells with random
  // waits, so both long back-to-back runs and gaps at every phase of the work occur.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Sender: offers one queued sample at a time and holds it until the transfer happens.
  int unsigned sender_gap = 0;
  bit          sender_calm = 1'b0;

  always @(negedge clk_i) begin : driver
    sample_item_t item;
    if (rst_n && samples_taken == samples_offered) begin
      if (sender_gap > 0) begin
        in_valid <= 1'b0;
        sender_gap--;
      end else if (line_items.size() > 0) begin
        item = line_items.pop_front();
        sample_d <= item.value;
        final_d  <= item.ends_line;
        in_valid <= 1'b1;
        samples_offered++;
        sender_gap = draw_wait(sender_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls a random number of cycles before each result. Once, early in the
  // random part, it holds off for a long stretch so that the output register fills and
  // the block has to stall its input while the sender keeps offering samples.
  int unsigned receiver_wait = 0;
  int unsigned results_seen = 0;
  bit          receiver_calm = 1'b0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk_i) begin : receiver
    if (results_taken != results_seen) begin
      results_seen  = results_taken;
      receiver_wait = draw_wait(receiver_calm);
      if (!long_hold_done && results_taken >= 120) begin
        receiver_wait  = 300;
        long_hold_done = 1'b1;
      end
    end
    if (receiver_wait > 0) begin
      out_stall <= 1'b1;
      receiver_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checks each result transfer against the oldest expectation, then feeds the input
  // transfer of the same edge into the shadow model. Checking first keeps a result and
  // the sample that arrives with it apart.
  always @(posedge clk_i) begin : monitor
    point_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, derivative", derivative, 0);
        end else begin
          want = pending_results.pop_front();
          if (derivative !== want.derivative)
            report_mismatch("derivative", derivative, want.derivative);
          if (point_index !== want.point)
            report_mismatch("point_index", point_index, want.point);
          if (run_end !== want.run_end)
            report_mismatch("run_end", run_end, want.run_end);
        end
        results_taken <= results_taken + 1;
      end
      if (in_valid && !in_stall) begin
        absorb_sample(sample_d, final_d);
        samples_taken <= samples_taken + 1;
      end
    end
  end

  // Register writes only happen while the block is idle, so the shadow copy is updated
  // at the same moment.
  task automatic write_reg(lsg_pkg::cfg_idx_e idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      lsg_pkg::CFG_LEFT_MODE:   left_mode_q   = data[MODE_W-1:0];
      lsg_pkg::CFG_RIGHT_MODE:  right_mode_q  = data[MODE_W-1:0];
      lsg_pkg::CFG_LEFT_VALUE:  left_value_q  = data;
      lsg_pkg::CFG_RIGHT_VALUE: right_value_q = data;
      lsg_pkg::CFG_SPACING:     spacing_q     = data[SPACING_W-1:0];
      lsg_pkg::CFG_SCALE:       scale_q       = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [MODE_W-1:0] lm, logic [MODE_W-1:0] rm,
      logic [DATA_W-1:0] lv, logic [DATA_W-1:0] rv, logic [DATA_W-1:0] sp,
      logic [DATA_W-1:0] sc);
    write_reg(lsg_pkg::CFG_LEFT_MODE, DATA_W'(lm));
    write_reg(lsg_pkg::CFG_RIGHT_MODE, DATA_W'(rm));
    write_reg(lsg_pkg::CFG_LEFT_VALUE, lv);
    write_reg(lsg_pkg::CFG_RIGHT_VALUE, rv);
    write_reg(lsg_pkg::CFG_SPACING, sp);
    write_reg(lsg_pkg::CFG_SCALE, sc);
  endtask

  // Waits until every sample has been taken and every result checked, then lets the
  // block finish any sample that causes no result.
  task automatic wait_idle();
    while (line_items.size() != 0 || samples_taken != samples_offered ||
           pending_results.size() != 0)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic push_sample(logic signed [DATA_W-1:0] value, logic ends);
    sample_item_t item;
    item.value     = value;
    item.ends_line = ends;
    line_items.push_back(item);
  endtask

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly moderate values so that results vary, with full-range words and extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) return pick_extreme();
    if (k <= 3) return $urandom();
    return DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
  endfunction

  task automatic pick_settings();
    logic [DATA_W-1:0] lv, rv, sp, sc;
    lv = ($urandom_range(0, 3) == 0) ? pick_extreme() : pick_sample();
    rv = ($urandom_range(0, 3) == 0) ? pick_extreme() : pick_sample();
    case ($urandom_range(0, 5))
      0:       sp = '0;
      1:       sp = 32'h7fff_ffff;
      2:       sp = $urandom();
      default: sp = $urandom_range(0, 32'h0004_0000);
    endcase
    if ($urandom_range(0, 5) == 0) sc = pick_extreme();
    else sc = DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    write_all(MODE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)), lv, rv, sp, sc);
  endtask

  initial begin : stimulus
    int unsigned phase_items, len;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Reset configuration: periodic at both ends, unit spacing and scale.
    push_sample(Q_MAX, 1'b1);                       // single-sample line
    push_sample(Q_MIN, 1'b0);                       // two-sample line, saturating
    push_sample(Q_MAX, 1'b1);
    push_sample(32'sd0, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(32'sd1, 1'b0);
    push_sample(Q_MIN, 1'b1);
    push_sample(32'sh0001_0000, 1'b0);
    push_sample(32'sh0002_0000, 1'b0);
    push_sample(32'sh0004_0000, 1'b0);
    push_sample(32'sh0002_0000, 1'b0);
    push_sample(32'sh0001_0000, 1'b1);
    wait_idle();

    write_all(lsg_pkg::MODE_DIRICHLET, lsg_pkg::MODE_NEUMANN, Q_MAX, Q_MIN, 32'hffff_ffff,
              Q_MAX);
    push_sample(32'sh0003_8000, 1'b0);
    push_sample(-32'sh0001_4000, 1'b0);
    push_sample(32'sh0000_0001, 1'b1);
    push_sample(Q_MIN, 1'b1);
    wait_idle();

    write_all(MODE_UNUSED, lsg_pkg::MODE_DIRICHLET, Q_MIN, Q_MAX, 32'h0000_0000, Q_MIN);
    push_sample(32'sh0000_8000, 1'b0);
    push_sample(-32'sh0000_8000, 1'b1);
    push_sample(Q_MAX, 1'b0);
    push_sample(Q_MIN, 1'b0);
    push_sample(Q_MAX, 1'b0);
    push_sample(32'sh1234_5678, 1'b1);
    wait_idle();

    write_all(lsg_pkg::MODE_NEUMANN, MODE_UNUSED, 32'sh0002_0000, -32'sh0001_0000,
              32'h0000_8000, 32'h0000_0000);
    push_sample(32'sh0001_0000, 1'b0);
    push_sample(32'sh0005_0000, 1'b0);
    push_sample(-32'sh0002_0000, 1'b1);
    wait_idle();

    // Random part: ten settings, at least 32 samples of mostly short lines under each.
    for (int unsigned phase = 0; phase < 10; phase++) begin
      pick_settings();
      phase_items = 0;
      while (phase_items < 32) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        for (int unsigned n = 0; n < len; n++)
          push_sample(pick_sample(), n == len - 1);
        phase_items += len;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("[laplacian_stencil_1d_ghost_bc] OK");
    end else begin
      $display("[laplacian_stencil_1d_ghost_bc] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, including stalls and the long hold.
  initial begin : watchdog
    #4000000;
    $display("[laplacian_stencil_1d_ghost_bc] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
sv/lsg_pkg.sv
sv/lsg_ctrl.sv
sv/lsg_dp.sv
sv/laplacian_stencil_1d_ghost_bc.sv
test/laplacian_stencil_1d_ghost_bc_tb.sv
